// File: hw/rtl/bounded_deque_with_value_delete_core_macros.svh
// Assertion macros for the bounded deque core checker.
// No dependencies; included by the checker file.
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_CORE_MACROS_SVH

// Check a property outside of reset.
`define BDQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property at every edge, reset included.
`define BDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hw/rtl/bdq_pkg.sv
// Shared constants for the bounded deque core: command and result codes,
// default depth. No dependencies.
package bdq_pkg;

    localparam int BDQ_DEPTH = 16;

    localparam logic [3:0] F_PUSH_FRONT = 4'd0;
    localparam logic [3:0] F_PUSH_BACK  = 4'd1;
    localparam logic [3:0] F_POP_FRONT  = 4'd2;
    localparam logic [3:0] F_POP_BACK   = 4'd3;
    localparam logic [3:0] F_CLEAR      = 4'd4;
    localparam logic [3:0] F_REMOVE     = 4'd5;
    localparam logic [3:0] F_DUMP_ALL   = 4'd6;
    localparam logic [3:0] F_DUMP_FIRST = 4'd7;
    localparam logic [3:0] F_DUMP_LAST  = 4'd8;

    localparam logic [1:0] KIND_ELEM  = 2'd0;
    localparam logic [1:0] KIND_BLANK = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

endpackage

// File: hw/rtl/bdq_mem.sv
// Entry storage for the bounded deque: one write port, one read port with
// registered read data. No dependencies.
module bdq_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IW-1:0]        i_waddr,
    input  logic signed [31:0]   i_wdata,
    input  logic                 i_re,
    input  logic [IW-1:0]        i_raddr,
    output logic signed [31:0]   o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bdq_slot.sv
// Shared slot unit: maps a logical position to a physical slot of the
// circular store, head plus position modulo depth. No dependencies.
module bdq_slot #(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic [IW-1:0] i_head,
    input  logic [IW-1:0] i_pos,
    output logic [IW-1:0] o_slot
);

    localparam logic [IW:0] DEPTH_S = (IW+1)'(DEPTH);

    logic [IW:0] sum;
    logic [IW:0] wrapped;

    always_comb begin
        sum     = {1'b0, i_head} + {1'b0, i_pos};
        wrapped = sum - DEPTH_S;
        if (sum >= DEPTH_S) begin
            o_slot = wrapped[IW-1:0];
        end else begin
            o_slot = sum[IW-1:0];
        end
    end

endmodule

// File: hw/rtl/bounded_deque_with_value_delete_core.sv
// Bounded deque core: sequencer, occupancy and head tracking, result register.
// Depends on bdq_pkg, bdq_mem and bdq_slot.
//
// A bounded double-ended queue of DEPTH signed 32-bit values. Push, pop and
// clear commands are handled in the idle state. Remove by value reads and
// compares entries from the front up to the first match, then moves each
// later entry one place toward the front to close the gap and drops the
// back entry. A dump reads each result in turn; a notice is a single result.
// Every read goes through the single read port of the entry memory, whose
// read data is registered, and through the one slot unit. A result waits
// in the output register while the sequencer moves on; a command is taken
// only while the sequencer is idle.
module bounded_deque_with_value_delete_core import bdq_pkg::*; #(
    parameter int DEPTH = BDQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_func,
    input  logic signed [31:0]  i_operand,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_element,
    output logic [1:0]          o_kind,
    output logic                o_last_of_run
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ONE       = 3'd1;
    localparam logic [2:0] S_SRCH_RD   = 3'd2;
    localparam logic [2:0] S_SRCH_CMP  = 3'd3;
    localparam logic [2:0] S_SHIFT_RD  = 3'd4;
    localparam logic [2:0] S_SHIFT_WR  = 3'd5;
    localparam logic [2:0] S_DUMP_RD   = 3'd6;
    localparam logic [2:0] S_DUMP_EMIT = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [IW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_occ, n_occ;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_end, n_end;
    logic signed [31:0]  r_val, n_val;
    logic [1:0]          r_note, n_note;
    logic                r_out_valid, n_out_valid;
    logic signed [31:0]  r_element, n_element;
    logic [1:0]          r_kind, n_kind;
    logic                r_last, n_last;

    logic                accept;
    logic                out_free;
    logic [CW-1:0]       pos_plus;
    logic [IW-1:0]       unit_pos;
    logic [IW-1:0]       slot;
    logic [IW-1:0]       head_dec;
    logic                neg_or_zero;
    logic [CW-1:0]       sat_cnt;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic signed [31:0]  mem_wdata;
    logic                mem_re;
    logic signed [31:0]  mem_rdata;

    bdq_slot #(.DEPTH(DEPTH), .IW(IW)) u_slot (
        .i_head (r_head),
        .i_pos  (unit_pos),
        .o_slot (slot)
    );

    bdq_mem #(.DEPTH(DEPTH), .IW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (slot),
        .o_rdata (mem_rdata)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign pos_plus = r_pos + CW'(1);
    assign head_dec = (r_head == '0) ? LAST_SLOT : r_head - IW'(1);
    assign neg_or_zero = (i_operand == 32'sd0) || i_operand[31];

    always_comb begin
        if ($unsigned(i_operand) > 32'(r_occ)) begin
            sat_cnt = r_occ;
        end else begin
            sat_cnt = i_operand[CW-1:0];
        end
    end

    // one slot unit, its position chosen by state
    always_comb begin
        case (r_state)
            S_IDLE: begin
                if (i_func == F_POP_FRONT) begin
                    unit_pos = IW'(1);
                end else begin
                    unit_pos = r_occ[IW-1:0];
                end
            end
            S_SHIFT_RD: unit_pos = pos_plus[IW-1:0];
            default:    unit_pos = r_pos[IW-1:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_occ       = r_occ;
        n_pos       = r_pos;
        n_end       = r_end;
        n_val       = r_val;
        n_note      = r_note;
        n_out_valid = r_out_valid && !i_ready;
        n_element   = r_element;
        n_kind      = r_kind;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_waddr   = slot;
        mem_wdata   = i_operand;
        mem_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        F_PUSH_FRONT: begin
                            if (r_occ < DEPTH_C) begin
                                mem_we    = 1'b1;
                                mem_waddr = head_dec;
                                n_head    = head_dec;
                                n_occ     = r_occ + CW'(1);
                            end
                        end
                        F_PUSH_BACK: begin
                            if (r_occ < DEPTH_C) begin
                                mem_we = 1'b1;
                                n_occ  = r_occ + CW'(1);
                            end
                        end
                        F_POP_FRONT: begin
                            if (r_occ != '0) begin
                                n_head = slot;
                                n_occ  = r_occ - CW'(1);
                            end
                        end
                        F_POP_BACK: begin
                            if (r_occ != '0) begin
                                n_occ = r_occ - CW'(1);
                            end
                        end
                        F_CLEAR: begin
                            n_head = '0;
                            n_occ  = '0;
                        end
                        F_REMOVE: begin
                            n_val   = i_operand;
                            n_pos   = '0;
                            n_state = S_SRCH_RD;
                        end
                        F_DUMP_ALL, F_DUMP_FIRST, F_DUMP_LAST: begin
                            if (r_occ == '0) begin
                                n_note  = KIND_EMPTY;
                                n_state = S_ONE;
                            end else if (i_func == F_DUMP_FIRST && neg_or_zero) begin
                                n_note  = KIND_BLANK;
                                n_state = S_ONE;
                            end else begin
                                n_state = S_DUMP_RD;
                                n_end   = r_occ;
                                n_pos   = '0;
                                if (i_func == F_DUMP_FIRST) begin
                                    n_end = sat_cnt;
                                end else if (i_func == F_DUMP_LAST) begin
                                    if (neg_or_zero) begin
                                        n_pos = r_occ - CW'(1);
                                    end else begin
                                        n_pos = r_occ - sat_cnt;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_element   = 32'sd0;
                    n_kind      = r_note;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SRCH_RD: begin
                if (r_pos == r_occ) begin
                    n_state = S_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (mem_rdata == r_val) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_pos   = pos_plus;
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                // past the back entry: the gap is closed, drop the back
                if (pos_plus >= r_occ) begin
                    n_occ   = r_occ - CW'(1);
                    n_state = S_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_pos     = pos_plus;
                n_state   = S_SHIFT_RD;
            end
            S_DUMP_RD: begin
                mem_re  = 1'b1;
                n_state = S_DUMP_EMIT;
            end
            S_DUMP_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_element   = mem_rdata;
                    n_kind      = KIND_ELEM;
                    n_last      = (pos_plus == r_end);
                    n_pos       = pos_plus;
                    n_state     = (pos_plus == r_end) ? S_IDLE : S_DUMP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_end     <= n_end;
        r_val     <= n_val;
        r_note    <= n_note;
        r_element <= n_element;
        r_kind    <= n_kind;
        r_last    <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_element     = r_element;
    assign o_kind        = r_kind;
    assign o_last_of_run = r_last;

endmodule

// File: hw/rtl/bdq_checker.sv
// Port-level checker for the bounded deque core, bound to every core instance.
// Depends on bdq_pkg and bounded_deque_with_value_delete_core_macros.svh.
`include "bounded_deque_with_value_delete_core_macros.svh"

module bdq_checker import bdq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic [3:0]          i_func,
    input logic signed [31:0]  i_operand,
    input logic                o_valid,
    input logic                i_ready,
    input logic signed [31:0]  o_element,
    input logic [1:0]          o_kind,
    input logic                o_last_of_run
);

    // notices carry no element and end their run
    `BDQ_ASSERT(a_notice_shape, i_clk, i_rst_n, o_valid && o_kind != KIND_ELEM |-> o_element == 32'sd0 && o_last_of_run && (o_kind == KIND_BLANK || o_kind == KIND_EMPTY), "notice result malformed")

    // a taken dump command leaves the block not ready in the next cycle
    `BDQ_ASSERT(a_dump_busy, i_clk, i_rst_n, i_valid && o_ready && (i_func == F_DUMP_ALL || i_func == F_DUMP_FIRST || i_func == F_DUMP_LAST) |=> !o_ready, "dump did not hold off input")

    // a stalled result transfer holds
    `BDQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_element) && $stable(o_kind) && $stable(o_last_of_run), "stalled result changed")

    // nothing is offered right after reset
    `BDQ_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind bounded_deque_with_value_delete_core bdq_checker u_bdq_checker (.*);

// File: verif/bdq_dump_checker.sv
// Watches both channels of the bounded deque core and predicts its dump output.
// Depends on bdq_pkg for command and result codes and the depth.
`timescale 1ns / 100ps

module bdq_dump_checker import bdq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  logic               i_cmd_ready,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_operand,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic signed [31:0] i_element,
    input  logic [1:0]         i_kind,
    input  logic               i_last_of_run,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [31:0] element;
        logic [1:0]         kind;
        logic               last_of_run;
    } t_dump_result;

    logic signed [31:0] slot_mem [BDQ_DEPTH];
    int unsigned        front_slot;
    int unsigned        fill_count;
    t_dump_result       expected_dumps [$];

    function automatic int unsigned phys(int unsigned pos);
        int unsigned s;
        s = front_slot + pos;
        if (s >= BDQ_DEPTH) s -= BDQ_DEPTH;
        return s;
    endfunction

    task automatic queue_notice(logic [1:0] kind);
        t_dump_result r;
        r.element     = '0;
        r.kind        = kind;
        r.last_of_run = 1'b1;
        expected_dumps.push_back(r);
    endtask

    task automatic queue_range(int unsigned from, int unsigned count);
        t_dump_result r;
        for (int unsigned i = 0; i < count; i++) begin
            r.element     = slot_mem[phys(from + i)];
            r.kind        = KIND_ELEM;
            r.last_of_run = (i + 1 == count);
            expected_dumps.push_back(r);
        end
    endtask

    task automatic apply_command(logic [3:0] func, logic signed [31:0] value);
        logic [31:0] count_req;
        int unsigned n;
        int unsigned idx;
        logic        nonpositive;
        count_req   = value;
        nonpositive = (value <= 0);
        n = (count_req > fill_count) ? fill_count : count_req;
        case (func)
            F_PUSH_FRONT: begin
                if (fill_count < BDQ_DEPTH) begin
                    front_slot = (front_slot == 0) ? BDQ_DEPTH - 1 : front_slot - 1;
                    slot_mem[front_slot] = value;
                    fill_count++;
                end
            end
            F_PUSH_BACK: begin
                if (fill_count < BDQ_DEPTH) begin
                    slot_mem[phys(fill_count)] = value;
                    fill_count++;
                end
            end
            F_POP_FRONT: begin
                if (fill_count > 0) begin
                    front_slot = phys(1);
                    fill_count--;
                end
            end
            F_POP_BACK: begin
                if (fill_count > 0) fill_count--;
            end
            F_CLEAR: begin
                front_slot = 0;
                fill_count = 0;
            end
            F_REMOVE: begin
                idx = 0;
                while (idx < fill_count && slot_mem[phys(idx)] != value) idx++;
                // close up the gap left by the first match
                if (idx < fill_count) begin
                    for (; idx + 1 < fill_count; idx++)
                        slot_mem[phys(idx)] = slot_mem[phys(idx + 1)];
                    fill_count--;
                end
            end
            F_DUMP_ALL: begin
                if (fill_count == 0) queue_notice(KIND_EMPTY);
                else queue_range(0, fill_count);
            end
            F_DUMP_FIRST: begin
                if (fill_count == 0) queue_notice(KIND_EMPTY);
                else if (nonpositive) queue_notice(KIND_BLANK);
                else queue_range(0, n);
            end
            F_DUMP_LAST: begin
                if (fill_count == 0) begin
                    queue_notice(KIND_EMPTY);
                end else begin
                    if (nonpositive) n = 1;
                    queue_range(fill_count - n, n);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_dump_result want;
        if (expected_dumps.size() == 0) begin
            $error("result with none expected: element %0d kind %0d last %0d",
                   i_element, i_kind, i_last_of_run);
            o_fail_count++;
        end else begin
            want = expected_dumps.pop_front();
            if (i_element !== want.element) begin
                $error("element: expected %0d, actual %0d", want.element, i_element);
                o_fail_count++;
            end
            if (i_kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, i_kind);
                o_fail_count++;
            end
            if (i_last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, actual %0d",
                       want.last_of_run, i_last_of_run);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot   = 0;
            fill_count   = 0;
            o_fail_count = 0;
            expected_dumps.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) apply_command(i_func, i_operand);
            if (i_res_valid && i_res_ready) check_result();
        end
        o_pending = expected_dumps.size();
    end

endmodule

// File: verif/tb_top.sv
// Stimulus and verdict for the bounded deque core regression.
// Depends on bdq_pkg, the core RTL and bdq_dump_checker.
`timescale 1ns / 100ps

module tb_top;
    import bdq_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_CMDS  = 300;

    logic               i_clk;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic [3:0]         i_func    = F_CLEAR;
    logic signed [31:0] i_operand = '0;
    logic               i_ready   = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_element;
    logic [1:0]         o_kind;
    logic               o_last_of_run;

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    bit  no_idle     = 1'b0;

    bounded_deque_with_value_delete_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_operand     (i_operand),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_element     (o_element),
        .o_kind        (o_kind),
        .o_last_of_run (o_last_of_run)
    );

    bdq_dump_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_ready   (o_ready),
        .i_func        (i_func),
        .i_operand     (i_operand),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_element     (o_element),
        .i_kind        (o_kind),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // stall the result side at random, except during the no-idle stretch
    always @(posedge i_clk) begin
        if (i_rst_n) i_ready <= no_idle || ($urandom_range(0, 99) >= 34);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("bounded_deque_with_value_delete_core regression: fail");
        $finish;
    end

    task automatic send_cmd(logic [3:0] func, logic signed [31:0] operand);
        int gap;
        i_valid   <= 1'b1;
        i_func    <= func;
        i_operand <= operand;
        do @(posedge i_clk); while (!o_ready);
        // transfer done at this edge; hold valid high unless idling next
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 34) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] pool [8];
        pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                 32'sd5, 32'sd42, -32'sd7};
        if ($urandom_range(0, 99) < 60) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 20);
        if (r < 80) return $urandom | 32'h8000_0000;
        if (r < 90) return 32'sd0;
        return $urandom;
    endfunction

    initial begin
        int          sent;
        int          r;
        bit          filling;
        logic [3:0]  func;
        logic signed [31:0] operand;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-queue cases, extremes, count edge cases, ignored codes
        send_cmd(F_DUMP_ALL,   32'sd0);
        send_cmd(F_DUMP_FIRST, 32'sd3);
        send_cmd(F_DUMP_LAST,  32'sd3);
        send_cmd(F_POP_FRONT,  32'sd0);
        send_cmd(F_POP_BACK,   32'sd0);
        send_cmd(F_REMOVE,     32'sd0);
        send_cmd(F_PUSH_FRONT, 32'sh7fffffff);
        send_cmd(F_PUSH_BACK,  32'sh80000000);
        send_cmd(F_PUSH_FRONT, -32'sd1);
        send_cmd(F_PUSH_BACK,  32'sd0);
        send_cmd(F_DUMP_ALL,   32'sd0);
        send_cmd(F_DUMP_FIRST, 32'sd0);
        send_cmd(F_DUMP_FIRST, -32'sd5);
        send_cmd(F_DUMP_FIRST, 32'sd2);
        send_cmd(F_DUMP_FIRST, 32'sh7fffffff);
        send_cmd(F_DUMP_LAST,  32'sd0);
        send_cmd(F_DUMP_LAST,  32'sh80000000);
        send_cmd(F_DUMP_LAST,  32'sd2);
        send_cmd(F_DUMP_LAST,  32'sd1000);
        send_cmd(F_REMOVE,     -32'sd1);
        send_cmd(F_REMOVE,     32'sd12345);
        send_cmd(F_DUMP_LAST + 4'd1, 32'sd0);
        send_cmd(4'hf,         32'shffffffff);
        send_cmd(F_CLEAR,      32'sd0);
        send_cmd(F_DUMP_ALL,   32'sd0);

        // random: alternate fill-biased and drain-biased stretches
        sent = 0;
        while (sent < RANDOM_CMDS) begin
            no_idle = (sent >= 140 && sent < 200);
            filling = ((sent / 40) % 2) == 0;
            r = $urandom_range(0, 99);
            operand = pick_value();
            if (r < (filling ? 50 : 20)) begin
                func = $urandom_range(0, 1) ? F_PUSH_FRONT : F_PUSH_BACK;
            end else if (r < (filling ? 60 : 55)) begin
                func = $urandom_range(0, 1) ? F_POP_FRONT : F_POP_BACK;
            end else if (r < (filling ? 75 : 70)) begin
                func = F_REMOVE;
            end else if (r < 95) begin
                func = F_DUMP_ALL + 4'($urandom_range(0, 2));
                operand = pick_count();
            end else if (r == 95) begin
                func = F_CLEAR;
            end else begin
                func = F_DUMP_LAST + 4'($urandom_range(1, 7));
            end
            send_cmd(func, operand);
            if (func <= F_DUMP_LAST) sent++;
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0) $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("bounded_deque_with_value_delete_core regression: pass");
        end else begin
            $display("bounded_deque_with_value_delete_core regression: fail");
        end
        $finish;
    end

endmodule
